@@ rtl/assert_macros.svh @@
// Assertion macros used by the router back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// An expression that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: invariant violated");

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("%m: same-cycle implication violated");

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("%m: next-cycle implication violated");

`endif

@@ rtl/sbdr_pkg.sv @@
// Shared types and constants of the seed base dispatch router.
`timescale 1ns / 1ps

package sbdr_pkg;

   localparam int BASE_QUEUE_DEPTH  = 16;
   localparam int STORE_QUEUE_DEPTH = 16;
   localparam int INDEX_BITS        = 6;
   localparam int CMD_QUEUE_DEPTH   = 2;

   localparam int NUM_BASES = 4;
   localparam int BASE_W    = $clog2(NUM_BASES);
   localparam int INDEX_W   = 6;
   localparam int SHIFT_W   = 6;
   localparam int CODE_W    = 3;

   localparam int BQ_SLOT_W = $clog2(BASE_QUEUE_DEPTH);
   localparam int BQ_CNT_W  = $clog2(BASE_QUEUE_DEPTH + 1);
   localparam int SQ_SLOT_W = $clog2(STORE_QUEUE_DEPTH);
   localparam int SQ_CNT_W  = $clog2(STORE_QUEUE_DEPTH + 1);

   localparam int REQ_TDATA_W = 176;
   localparam int REQ_TUSER_W = 6;
   localparam int RSP_TDATA_W = 184;
   localparam int RSP_TUSER_W = 3;

   localparam logic [CODE_W-1:0] CODE_STORE = 3'd7;

   localparam logic [INDEX_W-1:0] INDEX_MASK =
      (INDEX_BITS >= INDEX_W) ? {INDEX_W{1'b1}} : INDEX_W'((1 << INDEX_BITS) - 1);

   typedef enum logic [2:0] {
      MODE_OFFER      = 3'd0,
      MODE_POP_BASE   = 3'd1,
      MODE_POP_STORE  = 3'd2,
      MODE_PEEK_BASE  = 3'd3,
      MODE_PEEK_STORE = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_DISPATCHED = 3'd0,
      ST_STORED     = 3'd1,
      ST_STALL      = 3'd2,
      ST_INVALID    = 3'd3,
      ST_READ_OK    = 3'd4,
      ST_EMPTY      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      KIND_BASE_PUSH  = 3'd0,
      KIND_STORE_PUSH = 3'd1,
      KIND_INVALID    = 3'd2,
      KIND_BASE_READ  = 3'd3,
      KIND_STORE_READ = 3'd4
   } kind_type;

   typedef enum logic {
      BK_EXEC = 1'b0,
      BK_LOAD = 1'b1
   } back_state_type;

   typedef struct packed {
      kind_type            kind;
      logic                pop;
      logic [BASE_W-1:0]   qsel;
      logic [INDEX_W-1:0]  index;
      logic [SHIFT_W-1:0]  shift;
      logic [31:0]         low;
      logic [31:0]         high;
      logic [31:0]         addr;
   } cmd_type;

endpackage

@@ rtl/sbdr_front.sv @@
// Front end: accepts request items and classifies them into queue commands.
`timescale 1ns / 1ps

module sbdr_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, seed_bits, base_shift, low_bound, high_bound, seed_addr, zero pad
   input  logic [sbdr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode, force_store, queue_select
   input  logic [sbdr_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            cmd_push,
   output sbdr_pkg::cmd_type               cmd_out,
   input  logic                            cmd_room
);

   sbdr_pkg::mode_type               mode;
   logic [63:0]                      seed_bits;
   logic [sbdr_pkg::SHIFT_W-1:0]     base_shift;
   logic [sbdr_pkg::CODE_W-1:0]      code;
   logic                             force_store;
   logic                             known_mode;

   assign mode        = sbdr_pkg::mode_type'(req_tuser[2:0]);
   assign force_store = req_tuser[3];
   assign seed_bits   = req_tdata[69:6];
   assign base_shift  = req_tdata[75:70];
   assign code        = sbdr_pkg::CODE_W'(seed_bits >> base_shift);

   always_comb begin
      cmd_out       = '0;
      cmd_out.kind  = sbdr_pkg::KIND_INVALID;
      cmd_out.shift = base_shift;
      cmd_out.low   = req_tdata[107:76];
      cmd_out.high  = req_tdata[139:108];
      cmd_out.addr  = req_tdata[171:140];
      known_mode    = 1'b1;
      unique case (mode)
         sbdr_pkg::MODE_OFFER: begin
            cmd_out.index = req_tdata[5:0] & sbdr_pkg::INDEX_MASK;
            if (code == sbdr_pkg::CODE_STORE || force_store) begin
               cmd_out.kind = sbdr_pkg::KIND_STORE_PUSH;
            end else if (code[2]) begin
               cmd_out.kind = sbdr_pkg::KIND_INVALID;
            end else begin
               cmd_out.kind = sbdr_pkg::KIND_BASE_PUSH;
               cmd_out.qsel = code[1:0];
            end
         end
         sbdr_pkg::MODE_POP_BASE, sbdr_pkg::MODE_PEEK_BASE: begin
            cmd_out.kind = sbdr_pkg::KIND_BASE_READ;
            cmd_out.pop  = (mode == sbdr_pkg::MODE_POP_BASE);
            cmd_out.qsel = req_tuser[5:4];
         end
         sbdr_pkg::MODE_POP_STORE, sbdr_pkg::MODE_PEEK_STORE: begin
            cmd_out.kind = sbdr_pkg::KIND_STORE_READ;
            cmd_out.pop  = (mode == sbdr_pkg::MODE_POP_STORE);
         end
         default: begin
            // Unused modes are taken and dropped without a result.
            known_mode = 1'b0;
         end
      endcase
   end

   assign req_tready = cmd_room;
   assign cmd_push   = req_tvalid && known_mode;

endmodule

@@ rtl/sbdr_cmd_queue.sv @@
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module sbdr_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  sbdr_pkg::cmd_type   wr_cmd,
   output logic                rd_valid,
   input  logic                rd_ready,
   output sbdr_pkg::cmd_type   rd_cmd
);

   localparam int PTR_W = (sbdr_pkg::CMD_QUEUE_DEPTH > 1) ? $clog2(sbdr_pkg::CMD_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(sbdr_pkg::CMD_QUEUE_DEPTH + 1);

   sbdr_pkg::cmd_type  entry_ff [sbdr_pkg::CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_write;
   logic               do_read;

   assign wr_ready = (count_ff != CNT_W'(sbdr_pkg::CMD_QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = entry_ff[rd_ptr_ff];
   assign do_write = wr_valid && wr_ready;
   assign do_read  = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_write) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(sbdr_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_read) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(sbdr_pkg::CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_write && !do_read) begin
         count_in = count_ff + 1'b1;
      end else if (do_read && !do_write) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

endmodule

@@ rtl/sbdr_back.sv @@
// Back end: executes queue commands against the base and store queues.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sbdr_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  sbdr_pkg::cmd_type               cmd_in,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // marked_index, head_low, head_high, head_index, head_shift, head_base,
   // store_addr_out, store_value_out, zero pad
   output logic [sbdr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [sbdr_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int BQ_ADDR_W    = sbdr_pkg::BASE_W + sbdr_pkg::BQ_SLOT_W;
   localparam int BQ_MEM_DEPTH = 1 << BQ_ADDR_W;
   localparam int BQ_WORD_W    = 64 + sbdr_pkg::INDEX_W + sbdr_pkg::SHIFT_W;
   localparam int SQ_WORD_W    = 96;
   localparam int BQ_SLOT_W    = sbdr_pkg::BQ_SLOT_W;
   localparam int BQ_CNT_W     = sbdr_pkg::BQ_CNT_W;
   localparam int SQ_SLOT_W    = sbdr_pkg::SQ_SLOT_W;
   localparam int SQ_CNT_W     = sbdr_pkg::SQ_CNT_W;

   sbdr_pkg::back_state_type state_ff, state_in;

   logic [BQ_SLOT_W-1:0] bq_head_ff  [sbdr_pkg::NUM_BASES];
   logic [BQ_SLOT_W-1:0] bq_head_in  [sbdr_pkg::NUM_BASES];
   logic [BQ_SLOT_W-1:0] bq_tail_ff  [sbdr_pkg::NUM_BASES];
   logic [BQ_SLOT_W-1:0] bq_tail_in  [sbdr_pkg::NUM_BASES];
   logic [BQ_CNT_W-1:0]  bq_count_ff [sbdr_pkg::NUM_BASES];
   logic [BQ_CNT_W-1:0]  bq_count_in [sbdr_pkg::NUM_BASES];
   logic [SQ_SLOT_W-1:0] sq_head_ff, sq_head_in;
   logic [SQ_SLOT_W-1:0] sq_tail_ff, sq_tail_in;
   logic [SQ_CNT_W-1:0]  sq_count_ff, sq_count_in;

   // Result of the execute step, waiting for the registered memory read.
   sbdr_pkg::status_type        pend_status_ff, pend_status_in;
   logic [sbdr_pkg::INDEX_W-1:0] pend_index_ff, pend_index_in;
   logic [sbdr_pkg::BASE_W-1:0]  pend_qsel_ff, pend_qsel_in;
   logic                         pend_base_hit_ff, pend_base_hit_in;
   logic                         pend_store_hit_ff, pend_store_hit_in;

   logic [BQ_WORD_W-1:0] bq_mem [BQ_MEM_DEPTH];
   logic [SQ_WORD_W-1:0] sq_mem [sbdr_pkg::STORE_QUEUE_DEPTH];
   logic [BQ_WORD_W-1:0] bq_rd_ff;
   logic [SQ_WORD_W-1:0] sq_rd_ff;
   logic                 bq_we, bq_re, sq_we, sq_re;
   logic [BQ_ADDR_W-1:0] bq_waddr, bq_raddr;
   logic [SQ_SLOT_W-1:0] sq_waddr, sq_raddr;
   logic [BQ_WORD_W-1:0] bq_wdata;
   logic [SQ_WORD_W-1:0] sq_wdata;

   logic                          rsp_valid_ff, rsp_valid_in;
   sbdr_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [sbdr_pkg::INDEX_W-1:0]  rsp_marked_ff, rsp_marked_in;
   logic [31:0]                   rsp_head_low_ff, rsp_head_low_in;
   logic [31:0]                   rsp_head_high_ff, rsp_head_high_in;
   logic [sbdr_pkg::INDEX_W-1:0]  rsp_head_index_ff, rsp_head_index_in;
   logic [sbdr_pkg::SHIFT_W-1:0]  rsp_head_shift_ff, rsp_head_shift_in;
   logic [sbdr_pkg::BASE_W-1:0]   rsp_head_base_ff, rsp_head_base_in;
   logic [31:0]                   rsp_store_addr_ff, rsp_store_addr_in;
   logic [63:0]                   rsp_store_value_ff, rsp_store_value_in;

   logic [sbdr_pkg::BASE_W-1:0] q;
   logic                        out_free;

   assign q        = cmd_in.qsel;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in           = state_ff;
      bq_head_in         = bq_head_ff;
      bq_tail_in         = bq_tail_ff;
      bq_count_in        = bq_count_ff;
      sq_head_in         = sq_head_ff;
      sq_tail_in         = sq_tail_ff;
      sq_count_in        = sq_count_ff;
      pend_status_in     = pend_status_ff;
      pend_index_in      = pend_index_ff;
      pend_qsel_in       = pend_qsel_ff;
      pend_base_hit_in   = pend_base_hit_ff;
      pend_store_hit_in  = pend_store_hit_ff;
      bq_we              = 1'b0;
      bq_re              = 1'b0;
      sq_we              = 1'b0;
      sq_re              = 1'b0;
      bq_waddr           = {q, bq_tail_ff[q]};
      bq_raddr           = {q, bq_head_ff[q]};
      bq_wdata           = {cmd_in.low, cmd_in.high, cmd_in.index, cmd_in.shift};
      sq_waddr           = sq_tail_ff;
      sq_raddr           = sq_head_ff;
      sq_wdata           = {cmd_in.addr, cmd_in.low, cmd_in.high};
      cmd_ready          = 1'b0;
      rsp_valid_in       = rsp_valid_ff && !rsp_tready;
      rsp_status_in      = rsp_status_ff;
      rsp_marked_in      = rsp_marked_ff;
      rsp_head_low_in    = rsp_head_low_ff;
      rsp_head_high_in   = rsp_head_high_ff;
      rsp_head_index_in  = rsp_head_index_ff;
      rsp_head_shift_in  = rsp_head_shift_ff;
      rsp_head_base_in   = rsp_head_base_ff;
      rsp_store_addr_in  = rsp_store_addr_ff;
      rsp_store_value_in = rsp_store_value_ff;

      unique case (state_ff)
         sbdr_pkg::BK_EXEC: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               state_in          = sbdr_pkg::BK_LOAD;
               pend_index_in     = cmd_in.index;
               pend_qsel_in      = q;
               pend_base_hit_in  = 1'b0;
               pend_store_hit_in = 1'b0;
               unique case (cmd_in.kind)
                  sbdr_pkg::KIND_STORE_PUSH: begin
                     if (sq_count_ff == SQ_CNT_W'(sbdr_pkg::STORE_QUEUE_DEPTH)) begin
                        pend_status_in = sbdr_pkg::ST_STALL;
                     end else begin
                        pend_status_in = sbdr_pkg::ST_STORED;
                        sq_we          = 1'b1;
                        sq_tail_in     = (sq_tail_ff == SQ_SLOT_W'(sbdr_pkg::STORE_QUEUE_DEPTH - 1))
                                         ? '0 : sq_tail_ff + 1'b1;
                        sq_count_in    = sq_count_ff + 1'b1;
                     end
                  end
                  sbdr_pkg::KIND_BASE_PUSH: begin
                     if (bq_count_ff[q] == BQ_CNT_W'(sbdr_pkg::BASE_QUEUE_DEPTH)) begin
                        pend_status_in = sbdr_pkg::ST_STALL;
                     end else begin
                        pend_status_in = sbdr_pkg::ST_DISPATCHED;
                        bq_we          = 1'b1;
                        bq_tail_in[q]  = (bq_tail_ff[q] == BQ_SLOT_W'(sbdr_pkg::BASE_QUEUE_DEPTH - 1))
                                         ? '0 : bq_tail_ff[q] + 1'b1;
                        bq_count_in[q] = bq_count_ff[q] + 1'b1;
                     end
                  end
                  sbdr_pkg::KIND_BASE_READ: begin
                     if (bq_count_ff[q] == '0) begin
                        pend_status_in = sbdr_pkg::ST_EMPTY;
                     end else begin
                        pend_status_in   = sbdr_pkg::ST_READ_OK;
                        pend_base_hit_in = 1'b1;
                        bq_re            = 1'b1;
                        if (cmd_in.pop) begin
                           bq_head_in[q]  = (bq_head_ff[q] ==
                                             BQ_SLOT_W'(sbdr_pkg::BASE_QUEUE_DEPTH - 1))
                                            ? '0 : bq_head_ff[q] + 1'b1;
                           bq_count_in[q] = bq_count_ff[q] - 1'b1;
                        end
                     end
                  end
                  sbdr_pkg::KIND_STORE_READ: begin
                     if (sq_count_ff == '0) begin
                        pend_status_in = sbdr_pkg::ST_EMPTY;
                     end else begin
                        pend_status_in    = sbdr_pkg::ST_READ_OK;
                        pend_store_hit_in = 1'b1;
                        sq_re             = 1'b1;
                        if (cmd_in.pop) begin
                           sq_head_in  = (sq_head_ff == SQ_SLOT_W'(sbdr_pkg::STORE_QUEUE_DEPTH - 1))
                                         ? '0 : sq_head_ff + 1'b1;
                           sq_count_in = sq_count_ff - 1'b1;
                        end
                     end
                  end
                  default: begin
                     pend_status_in = sbdr_pkg::ST_INVALID;
                  end
               endcase
            end
         end
         sbdr_pkg::BK_LOAD: begin
            // Hold the result here until the output register can take it.
            if (out_free) begin
               state_in           = sbdr_pkg::BK_EXEC;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = pend_status_ff;
               rsp_marked_in      = pend_index_ff;
               rsp_head_low_in    = pend_base_hit_ff ? bq_rd_ff[75:44] : '0;
               rsp_head_high_in   = pend_base_hit_ff ? bq_rd_ff[43:12] : '0;
               rsp_head_index_in  = pend_base_hit_ff ? bq_rd_ff[11:6] : '0;
               rsp_head_shift_in  = pend_base_hit_ff ? bq_rd_ff[5:0] : '0;
               rsp_head_base_in   = pend_base_hit_ff ? pend_qsel_ff : '0;
               rsp_store_addr_in  = pend_store_hit_ff ? sq_rd_ff[95:64] : '0;
               rsp_store_value_in = pend_store_hit_ff ? sq_rd_ff[63:0] : '0;
            end
         end
         default: begin
            state_in = sbdr_pkg::BK_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sbdr_pkg::BK_EXEC;
         rsp_valid_ff <= 1'b0;
         bq_head_ff   <= '{default: '0};
         bq_tail_ff   <= '{default: '0};
         bq_count_ff  <= '{default: '0};
         sq_head_ff   <= '0;
         sq_tail_ff   <= '0;
         sq_count_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bq_head_ff   <= bq_head_in;
         bq_tail_ff   <= bq_tail_in;
         bq_count_ff  <= bq_count_in;
         sq_head_ff   <= sq_head_in;
         sq_tail_ff   <= sq_tail_in;
         sq_count_ff  <= sq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_status_ff     <= pend_status_in;
      pend_index_ff      <= pend_index_in;
      pend_qsel_ff       <= pend_qsel_in;
      pend_base_hit_ff   <= pend_base_hit_in;
      pend_store_hit_ff  <= pend_store_hit_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_marked_ff      <= rsp_marked_in;
      rsp_head_low_ff    <= rsp_head_low_in;
      rsp_head_high_ff   <= rsp_head_high_in;
      rsp_head_index_ff  <= rsp_head_index_in;
      rsp_head_shift_ff  <= rsp_head_shift_in;
      rsp_head_base_ff   <= rsp_head_base_in;
      rsp_store_addr_ff  <= rsp_store_addr_in;
      rsp_store_value_ff <= rsp_store_value_in;
   end

   // Entry storage with one write and one registered read port each.
   always_ff @(posedge clock) begin
      if (bq_we) begin
         bq_mem[bq_waddr] <= bq_wdata;
      end
      if (bq_re) begin
         bq_rd_ff <= bq_mem[bq_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (sq_we) begin
         sq_mem[sq_waddr] <= sq_wdata;
      end
      if (sq_re) begin
         sq_rd_ff <= sq_mem[sq_raddr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0, rsp_store_value_ff, rsp_store_addr_ff, rsp_head_base_ff,
                        rsp_head_shift_ff, rsp_head_index_ff, rsp_head_high_ff,
                        rsp_head_low_ff, rsp_marked_ff};

   `ASSERT_ALWAYS(a_sq_count_bound, clock, reset,
      sq_count_ff <= SQ_CNT_W'(sbdr_pkg::STORE_QUEUE_DEPTH))
   `ASSERT_IMPLY(a_sq_empty_ptrs, clock, reset, sq_count_ff == '0, sq_head_ff == sq_tail_ff)
   `ASSERT_NEXT(a_exec_to_load, clock, reset,
      state_ff == sbdr_pkg::BK_EXEC && cmd_valid, state_ff == sbdr_pkg::BK_LOAD)
   `ASSERT_IMPLY(a_rsp_from_load, clock, reset,
      $rose(rsp_valid_ff), $past(state_ff == sbdr_pkg::BK_LOAD))

endmodule

@@ rtl/seed_base_dispatch_router_top.sv @@
// Top level of the seed base dispatch router.
`timescale 1ns / 1ps

// Usage: request items arrive on the req_ channel and each one produces a
// single result item on the rsp_ channel, in order. The mode in req_tuser
// selects an offer, a pop or a peek of a base queue, or a pop or a peek of
// the store queue; unused modes are accepted and produce no result.
// An accepted item is classified by the front end and written into a
// two-entry command queue. The back end takes one command, updates the
// queue pointers and issues the entry memory read, then, in the load
// state, loads the result register once the output register is free.
// The back end takes no new command until that result is loaded, due to
// the execute-then-load sequence around the registered read port of the
// entry memories.
// When the receiver holds rsp_tready low, the result stays in the output
// register, the back end holds its next result, and the command queue
// keeps accepting until it fills, after which req_tready falls.
// Reset empties all base and store queues and the command queue; entry
// storage itself is not cleared, and only written entries are read.

module seed_base_dispatch_router_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // entry_index, seed_bits, base_shift, low_bound, high_bound, seed_addr, zero pad
   input  logic [sbdr_pkg::REQ_TDATA_W-1:0] req_tdata,
   // mode, force_store, queue_select
   input  logic [sbdr_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // marked_index, head_low, head_high, head_index, head_shift, head_base,
   // store_addr_out, store_value_out, zero pad
   output logic [sbdr_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [sbdr_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   logic              front_push;
   logic              queue_room;
   sbdr_pkg::cmd_type front_cmd;
   logic              back_valid;
   logic              back_ready;
   sbdr_pkg::cmd_type back_cmd;

   sbdr_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_push   (front_push),
      .cmd_out    (front_cmd),
      .cmd_room   (queue_room)
   );

   sbdr_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_push),
      .wr_ready (queue_room),
      .wr_cmd   (front_cmd),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_cmd   (back_cmd)
   );

   sbdr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd_in     (back_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
